FILE: hw/rtl/i2cs_pkg.sv
// i2cs_pkg: shared types and constants of the i2c master transaction sequencer
// request and result payload structs, command, phase and status codes
// no dependencies
`default_nettype none

package i2cs_pkg;

    // payload store geometry
    localparam int unsigned PAYLOAD_DEPTH = 256;
    localparam int unsigned PAYLOAD_AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    // timeout register
    localparam int unsigned    TIMEOUT_W     = 17;
    localparam logic [16:0]    TIMEOUT_RESET = 17'd100000;
    localparam logic [16:0]    TICK_MAX      = 17'h1FFFF;

    // request commands
    typedef enum logic [3:0] {
        CMD_START_WRITE = 4'd0,
        CMD_START_READ  = 4'd1,
        CMD_READ_PTR1   = 4'd2,
        CMD_READ_PTR2   = 4'd3,
        CMD_TX_READY    = 4'd4,
        CMD_RX_BYTE     = 4'd5,
        CMD_NACK        = 4'd6,
        CMD_LOAD        = 4'd7,
        CMD_TICK        = 4'd8
    } t_cmd;

    // transaction phases
    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_W_START       = 4'd1,
        PH_W_PTR         = 4'd2,
        PH_W_DATA        = 4'd3,
        PH_R_START_PLAIN = 4'd4,
        PH_R_START_P1    = 4'd5,
        PH_R_START_P2    = 4'd6,
        PH_R_PTR_HI      = 4'd7,
        PH_R_PTR_DONE    = 4'd8,
        PH_R_DATA        = 4'd9
    } t_phase;

    // transaction status
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_BUSY       = 3'd1,
        ST_SUCCESS    = 3'd2,
        ST_ADDR_NACK  = 3'd3,
        ST_RADDR_NACK = 3'd4,
        ST_TIMEOUT    = 3'd5
    } t_status;

    // one request item
    typedef struct packed {
        logic [3:0] cmd;
        logic [6:0] slave_addr;
        logic [7:0] transfer_length;
        logic [7:0] pointer_first;
        logic [7:0] pointer_second;
        logic [7:0] bus_byte;
        logic [7:0] payload_index;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       start_req;
        logic       start_read;
        logic [6:0] bus_address;
        logic       stop_req;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic [2:0] status;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cs_if.sv
// i2cs_if: valid/ready channel interfaces for requests and results
// depends on i2cs_pkg for the payload structs
`default_nettype none

// request channel
interface i2cs_in_if;
    logic               valid;
    logic               ready;
    i2cs_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface i2cs_out_if;
    logic                valid;
    logic                ready;
    i2cs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/i2c_master_transaction_sequencer.sv
// i2c_master_transaction_sequencer: top level of the i2c transaction sequencer
// depends on i2cs_pkg, i2cs_if (i2cs_in_if, i2cs_out_if) and i2cs_ram
//
// Usage:
//   i_in carries one request per accepted item: a start command, a bus event
//   from the byte-level controller (transmit ready, received byte, nack, tick)
//   or a payload load. o_out gives exactly one result per request: byte to
//   send, start/stop requests, received byte with its index, and the status.
//   i_cfg_we/i_cfg_wdata write timeout_limit; write it only while idle.
//   Each result is registered in the first stage, then in the output register.
//   Throughput: one request per cycle while o_out is not stalled; the payload
//   store read for a transmitted byte is issued at the accept edge and its
//   registered data is merged in the second stage.
//   Reset (synchronous, active low): phase and status idle, counters and
//   pointers zero, timeout_limit 100000, both pipeline stages empty. The
//   payload store is not cleared; load every position before it is sent.
//   When the receiver stalls, the result waits in the output register, the
//   first stage still takes one more request, and i_in.ready then drops
//   until the output register drains.
`default_nettype none

module i2c_master_transaction_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,
    i2cs_in_if.sink          i_in,
    i2cs_out_if.source       o_out
);

    // architectural state
    i2cs_pkg::t_phase  r_phase,   n_phase;
    i2cs_pkg::t_status r_status,  n_status;
    logic [6:0]        r_target,  n_target;
    logic [7:0]        r_total,   n_total;
    logic [7:0]        r_ptr_hi,  n_ptr_hi;
    logic [7:0]        r_ptr_lo,  n_ptr_lo;
    logic [7:0]        r_bytes,   n_bytes;
    logic [16:0]       r_tick,    n_tick;
    logic [16:0]       r_limit;

    // pipeline stages
    logic                r_s1_vld;
    i2cs_pkg::t_out_item r_s1_item, n_s1_item;
    logic                r_s1_ram,  n_s1_ram;
    logic                r_out_vld;
    i2cs_pkg::t_out_item r_out_item;

    // handshake and store access
    logic                              accept;
    logic                              s1_adv;
    logic                              ram_we;
    logic [i2cs_pkg::PAYLOAD_AW-1:0]   ram_waddr;
    logic [i2cs_pkg::PAYLOAD_AW-1:0]   ram_raddr;
    logic [7:0]                        ram_rdata;
    logic [7:0]                        send_pos;
    logic [7:0]                        send_next;
    logic [8:0]                        rx_next;
    i2cs_pkg::t_out_item               s1_merged;

    assign s1_adv      = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_s1_vld || s1_adv;
    assign accept      = i_in.valid && i_in.ready;

    // payload send position: first byte after the pointer, else running count
    assign send_pos  = (r_phase == i2cs_pkg::PH_W_PTR) ? 8'd0 : r_bytes;
    assign send_next = send_pos + 8'd1;
    assign rx_next   = {1'b0, r_bytes} + 9'd1;
    assign ram_raddr = send_pos[i2cs_pkg::PAYLOAD_AW-1:0];
    assign ram_waddr = i_in.data.payload_index[i2cs_pkg::PAYLOAD_AW-1:0];

    // payload store
    i2cs_ram #(
        .WIDTH (8),
        .DEPTH (i2cs_pkg::PAYLOAD_DEPTH)
    ) u_payload (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.data.bus_byte),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state and result of one request
    always_comb begin
        n_phase   = r_phase;
        n_status  = r_status;
        n_target  = r_target;
        n_total   = r_total;
        n_ptr_hi  = r_ptr_hi;
        n_ptr_lo  = r_ptr_lo;
        n_bytes   = r_bytes;
        n_tick    = r_tick;
        n_s1_item = '0;
        n_s1_ram  = 1'b0;
        ram_we    = 1'b0;

        case (i2cs_pkg::t_cmd'(i_in.data.cmd))
            i2cs_pkg::CMD_START_WRITE,
            i2cs_pkg::CMD_START_READ,
            i2cs_pkg::CMD_READ_PTR1,
            i2cs_pkg::CMD_READ_PTR2: begin
                n_target = i_in.data.slave_addr;
                n_total  = i_in.data.transfer_length;
                n_ptr_hi = i_in.data.pointer_first;
                n_ptr_lo = i_in.data.pointer_second;
                n_bytes  = 8'd0;
                n_tick   = '0;
                n_status = i2cs_pkg::ST_BUSY;
                case (i2cs_pkg::t_cmd'(i_in.data.cmd))
                    i2cs_pkg::CMD_START_WRITE: n_phase = i2cs_pkg::PH_W_START;
                    i2cs_pkg::CMD_START_READ:  n_phase = i2cs_pkg::PH_R_START_PLAIN;
                    i2cs_pkg::CMD_READ_PTR1:   n_phase = i2cs_pkg::PH_R_START_P1;
                    default:                   n_phase = i2cs_pkg::PH_R_START_P2;
                endcase
                n_s1_item.start_req   = 1'b1;
                n_s1_item.bus_address = i_in.data.slave_addr;
            end
            i2cs_pkg::CMD_TX_READY: begin
                case (r_phase)
                    i2cs_pkg::PH_W_START: begin
                        n_s1_item.tx_valid = 1'b1;
                        n_s1_item.tx_byte  = r_ptr_hi;
                        n_phase            = i2cs_pkg::PH_W_PTR;
                    end
                    i2cs_pkg::PH_W_PTR,
                    i2cs_pkg::PH_W_DATA: begin
                        if (r_phase == i2cs_pkg::PH_W_PTR && r_total == 8'd0) begin
                            // zero-length write ends after the pointer
                            n_bytes            = 8'd0;
                            n_s1_item.stop_req = 1'b1;
                            n_status           = i2cs_pkg::ST_SUCCESS;
                            n_phase            = i2cs_pkg::PH_IDLE;
                        end else begin
                            n_s1_item.tx_valid = 1'b1;
                            n_s1_ram = ({1'b0, send_pos} < 9'(i2cs_pkg::PAYLOAD_DEPTH));
                            n_bytes  = send_next;
                            if (send_next == r_total) begin
                                n_s1_item.stop_req = 1'b1;
                                n_status           = i2cs_pkg::ST_SUCCESS;
                                n_phase            = i2cs_pkg::PH_IDLE;
                            end else begin
                                n_phase = i2cs_pkg::PH_W_DATA;
                            end
                        end
                    end
                    i2cs_pkg::PH_R_START_PLAIN,
                    i2cs_pkg::PH_R_PTR_DONE: begin
                        // repeated start in read mode
                        n_s1_item.start_req   = 1'b1;
                        n_s1_item.start_read  = 1'b1;
                        n_s1_item.bus_address = r_target;
                        n_bytes               = 8'd0;
                        if (r_total == 8'd0) begin
                            n_s1_item.stop_req = 1'b1;
                            n_status           = i2cs_pkg::ST_SUCCESS;
                            n_phase            = i2cs_pkg::PH_IDLE;
                        end else begin
                            n_phase = i2cs_pkg::PH_R_DATA;
                        end
                    end
                    i2cs_pkg::PH_R_START_P1: begin
                        n_s1_item.tx_valid = 1'b1;
                        n_s1_item.tx_byte  = r_ptr_hi;
                        n_phase            = i2cs_pkg::PH_R_PTR_DONE;
                    end
                    i2cs_pkg::PH_R_START_P2: begin
                        n_s1_item.tx_valid = 1'b1;
                        n_s1_item.tx_byte  = r_ptr_hi;
                        n_phase            = i2cs_pkg::PH_R_PTR_HI;
                    end
                    i2cs_pkg::PH_R_PTR_HI: begin
                        n_s1_item.tx_valid = 1'b1;
                        n_s1_item.tx_byte  = r_ptr_lo;
                        n_phase            = i2cs_pkg::PH_R_PTR_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            i2cs_pkg::CMD_RX_BYTE: begin
                if (r_phase == i2cs_pkg::PH_R_DATA) begin
                    n_s1_item.stop_req = (rx_next == {1'b0, r_total});
                    n_s1_item.rx_valid = 1'b1;
                    n_s1_item.rx_index = r_bytes;
                    n_s1_item.rx_byte  = i_in.data.bus_byte;
                    n_bytes            = rx_next[7:0];
                    if (rx_next[7:0] == r_total) begin
                        n_status = i2cs_pkg::ST_SUCCESS;
                        n_phase  = i2cs_pkg::PH_IDLE;
                    end
                end
            end
            i2cs_pkg::CMD_NACK: begin
                n_s1_item.stop_req = 1'b1;
                if (r_phase == i2cs_pkg::PH_W_START || r_phase == i2cs_pkg::PH_R_START_PLAIN ||
                    r_phase == i2cs_pkg::PH_R_START_P1 || r_phase == i2cs_pkg::PH_R_START_P2) begin
                    n_status = i2cs_pkg::ST_ADDR_NACK;
                    n_phase  = i2cs_pkg::PH_IDLE;
                end else if (r_phase == i2cs_pkg::PH_R_DATA && r_bytes == 8'd0) begin
                    n_status = i2cs_pkg::ST_RADDR_NACK;
                    n_phase  = i2cs_pkg::PH_IDLE;
                end
            end
            i2cs_pkg::CMD_LOAD: begin
                ram_we = accept &&
                         ({1'b0, i_in.data.payload_index} < 9'(i2cs_pkg::PAYLOAD_DEPTH));
            end
            i2cs_pkg::CMD_TICK: begin
                if (r_phase != i2cs_pkg::PH_IDLE) begin
                    if (r_tick < i2cs_pkg::TICK_MAX) begin
                        n_tick = r_tick + 17'd1;
                    end
                    if (n_tick >= r_limit) begin
                        n_status = i2cs_pkg::ST_TIMEOUT;
                        n_phase  = i2cs_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase

        n_s1_item.status = n_status;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= i2cs_pkg::PH_IDLE;
            r_status <= i2cs_pkg::ST_IDLE;
            r_target <= '0;
            r_total  <= '0;
            r_ptr_hi <= '0;
            r_ptr_lo <= '0;
            r_bytes  <= '0;
            r_tick   <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_target <= n_target;
            r_total  <= n_total;
            r_ptr_hi <= n_ptr_hi;
            r_ptr_lo <= n_ptr_lo;
            r_bytes  <= n_bytes;
            r_tick   <= n_tick;
        end
    end

    // timeout limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= i2cs_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // first stage: result fields waiting on the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= n_s1_item;
            r_s1_ram  <= n_s1_ram;
        end
    end

    // merge the payload byte
    always_comb begin
        s1_merged = r_s1_item;
        if (r_s1_ram) begin
            s1_merged.tx_byte = ram_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item <= s1_merged;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_item;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cs_ram.sv
// i2cs_ram: generic single-clock ram, one write and one read port
// registered read data, no reset on contents; no dependencies
`default_nettype none

module i2cs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cs_checker.sv
// i2cs_checker: port-level checks on the sequencer result channel
// depends on i2cs_pkg; bound to i2c_master_transaction_sequencer below
`default_nettype none

module i2cs_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire i2cs_pkg::t_out_item i_out_item
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("result changed while stalled");

    // a byte is never sent and received in one result
    a_tx_rx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_item.tx_valid && i_out_item.rx_valid))
        else $error("tx and rx in the same result");

    // start together with stop only for a zero-length read restart
    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.start_req && i_out_item.stop_req
            |-> i_out_item.start_read)
        else $error("stop with a write-mode start");

    // a received byte leaves the transaction busy or successful
    a_rx_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.rx_valid
            |-> (i_out_item.status == i2cs_pkg::ST_BUSY ||
                 i_out_item.status == i2cs_pkg::ST_SUCCESS))
        else $error("received byte with failure status");

endmodule

bind i2c_master_transaction_sequencer i2cs_checker u_i2cs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.data)
);

`default_nettype wire

FILE: tb/sv/i2c_master_transaction_sequencer_tb.sv
// i2c_master_transaction_sequencer_tb: self-checking testbench of the i2c transaction sequencer
// depends on i2cs_pkg, i2cs_if and the sequencer rtl; a scoreboard predicts every result
// and checks it in order, under random request gaps and result stalls

module i2c_master_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cs_pkg::*;

    // highest command code, including the unused ones
    localparam logic [3:0] CMD_CODE_MAX = 4'd15;
    // counted random requests per timeout setting
    localparam int PHASE_REQUESTS = 260;
    // mismatches printed in full
    localparam int MAX_REPORTS = 10;

    // predicts the sequencer and checks its results
    class txn_scoreboard;
        t_phase      phase;
        t_status     status;
        logic [6:0]  tgt_addr;
        logic [7:0]  byte_total;
        logic [7:0]  ptr_hi;
        logic [7:0]  ptr_lo;
        logic [7:0]  bytes_done;
        logic [16:0] tick_count;
        logic [16:0] timeout_limit;
        logic [7:0]  payload [PAYLOAD_DEPTH];
        bit          loaded [PAYLOAD_DEPTH];
        t_out_item   results_due [$];
        int          failures;

        function new();
            phase         = PH_IDLE;
            status        = ST_IDLE;
            tgt_addr      = '0;
            byte_total    = '0;
            ptr_hi        = '0;
            ptr_lo        = '0;
            bytes_done    = '0;
            tick_count    = '0;
            timeout_limit = TIMEOUT_RESET;
            failures      = 0;
            foreach (loaded[i]) begin
                loaded[i]  = 1'b0;
                payload[i] = '0;
            end
        endfunction

        function void close_txn(t_status st);
            status = st;
            phase  = PH_IDLE;
        endfunction

        // repeated start in read mode, zero-length read stops right here
        function void restart_read(inout t_out_item r);
            r.start_req   = 1'b1;
            r.start_read  = 1'b1;
            r.bus_address = tgt_addr;
            bytes_done    = '0;
            if (byte_total == '0) begin
                r.stop_req = 1'b1;
                close_txn(ST_SUCCESS);
            end else begin
                phase = PH_R_DATA;
            end
        endfunction

        function void send_payload(inout t_out_item r);
            r.tx_valid = 1'b1;
            r.tx_byte  = payload[bytes_done];
            bytes_done = bytes_done + 8'd1;
            if (bytes_done == byte_total) begin
                r.stop_req = 1'b1;
                close_txn(ST_SUCCESS);
            end else begin
                phase = PH_W_DATA;
            end
        endfunction

        // work out the result of one accepted request
        function void note_request(t_in_item it);
            t_out_item r;
            r = '0;
            case (it.cmd)
                CMD_START_WRITE, CMD_START_READ, CMD_READ_PTR1, CMD_READ_PTR2: begin
                    tgt_addr   = it.slave_addr;
                    byte_total = it.transfer_length;
                    ptr_hi     = it.pointer_first;
                    ptr_lo     = it.pointer_second;
                    bytes_done = '0;
                    tick_count = '0;
                    status     = ST_BUSY;
                    case (it.cmd)
                        CMD_START_WRITE: phase = PH_W_START;
                        CMD_START_READ:  phase = PH_R_START_PLAIN;
                        CMD_READ_PTR1:   phase = PH_R_START_P1;
                        default:         phase = PH_R_START_P2;
                    endcase
                    r.start_req   = 1'b1;
                    r.bus_address = it.slave_addr;
                end
                CMD_TX_READY: begin
                    case (phase)
                        PH_W_START: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = ptr_hi;
                            phase      = PH_W_PTR;
                        end
                        PH_W_PTR: begin
                            bytes_done = '0;
                            if (byte_total == '0) begin
                                r.stop_req = 1'b1;
                                close_txn(ST_SUCCESS);
                            end else begin
                                send_payload(r);
                            end
                        end
                        PH_W_DATA: send_payload(r);
                        PH_R_START_PLAIN, PH_R_PTR_DONE: restart_read(r);
                        PH_R_START_P1: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = ptr_hi;
                            phase      = PH_R_PTR_DONE;
                        end
                        PH_R_START_P2: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = ptr_hi;
                            phase      = PH_R_PTR_HI;
                        end
                        PH_R_PTR_HI: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = ptr_lo;
                            phase      = PH_R_PTR_DONE;
                        end
                        default: ;
                    endcase
                end
                CMD_RX_BYTE: begin
                    // stop goes out together with the last byte
                    if (phase == PH_R_DATA) begin
                        if (int'(bytes_done) + 1 == int'(byte_total))
                            r.stop_req = 1'b1;
                        r.rx_valid = 1'b1;
                        r.rx_index = bytes_done;
                        r.rx_byte  = it.bus_byte;
                        bytes_done = bytes_done + 8'd1;
                        if (bytes_done == byte_total)
                            close_txn(ST_SUCCESS);
                    end
                end
                CMD_NACK: begin
                    r.stop_req = 1'b1;
                    if (phase == PH_W_START || phase == PH_R_START_PLAIN ||
                        phase == PH_R_START_P1 || phase == PH_R_START_P2)
                        close_txn(ST_ADDR_NACK);
                    else if (phase == PH_R_DATA && bytes_done == '0)
                        close_txn(ST_RADDR_NACK);
                end
                CMD_LOAD: begin
                    payload[it.payload_index] = it.bus_byte;
                    loaded[it.payload_index]  = 1'b1;
                end
                CMD_TICK: begin
                    if (phase != PH_IDLE) begin
                        if (tick_count < TICK_MAX)
                            tick_count = tick_count + 17'd1;
                        if (tick_count >= timeout_limit)
                            close_txn(ST_TIMEOUT);
                    end
                end
                default: ;
            endcase
            r.status = status;
            results_due.push_back(r);
        endfunction

        function void flag(string what, t_out_item want, t_out_item got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t %s: expected tx %b/%h start %b/%b/%h stop %b rx %b/%h/%h st %0d",
                         $realtime, what, want.tx_valid, want.tx_byte, want.start_req,
                         want.start_read, want.bus_address, want.stop_req, want.rx_valid,
                         want.rx_index, want.rx_byte, want.status);
            if (failures <= MAX_REPORTS)
                $display("    actual tx %b/%h start %b/%b/%h stop %b rx %b/%h/%h st %0d",
                         got.tx_valid, got.tx_byte, got.start_req, got.start_read,
                         got.bus_address, got.stop_req, got.rx_valid, got.rx_index,
                         got.rx_byte, got.status);
        endfunction

        // compare one result with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (results_due.size() == 0) begin
                flag("result with no request pending", '0, got);
                return;
            end
            want = results_due.pop_front();
            if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                got.start_req !== want.start_req || got.start_read !== want.start_read ||
                got.bus_address !== want.bus_address || got.stop_req !== want.stop_req ||
                got.rx_valid !== want.rx_valid || got.rx_index !== want.rx_index ||
                got.rx_byte !== want.rx_byte || got.status !== want.status)
                flag("result mismatch", want, got);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [16:0] cfg_wdata;

    i2cs_in_if  req_ch ();
    i2cs_out_if res_ch ();

    txn_scoreboard txn_sb = new();
    bit            src_calm = 1'b0;
    int            issued;

    i2c_master_transaction_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_ch),
        .o_out       (res_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            txn_sb.check_result(res_ch.data);
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result sink with random stalls and calm stretches
    initial begin
        int  stall;
        int  r;
        bit  calm;
        stall        = 0;
        calm         = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                r = $urandom_range(99);
                if (!calm && r < 30)
                    stall = pick_gap();
            end
            if ($urandom_range(149) == 0)
                calm = !calm;
        end
    end

    function automatic t_in_item random_item(logic [3:0] cmd);
        t_in_item    it;
        logic [63:0] bits;
        bits               = {$urandom, $urandom};
        it.cmd             = cmd;
        it.slave_addr      = bits[6:0];
        it.transfer_length = bits[15:8];
        it.pointer_first   = bits[23:16];
        it.pointer_second  = bits[31:24];
        it.bus_byte        = bits[39:32];
        it.payload_index   = bits[47:40];
        return it;
    endfunction

    // drive one request and note it when taken
    task automatic send_request(t_in_item it);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if ($urandom_range(99) == 0)
            src_calm = !src_calm;
        repeat (gap) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        txn_sb.note_request(it);
    endtask

    task automatic send_cmd(logic [3:0] cmd, logic [6:0] addr, logic [7:0] len,
                            logic [7:0] p1, logic [7:0] p2, logic [7:0] db, logic [7:0] idx);
        t_in_item it;
        it = '{cmd, addr, len, p1, p2, db, idx};
        send_request(it);
    endtask

    task automatic load_payload(logic [7:0] idx);
        t_in_item it;
        it               = random_item(CMD_LOAD);
        it.payload_index = idx;
        send_request(it);
    endtask

    // new transaction of random kind and mostly small length
    task automatic begin_transaction();
        t_in_item   it;
        logic [3:0] kind;
        int         r;
        int         len;
        case ($urandom_range(3))
            0:       kind = CMD_START_WRITE;
            1:       kind = CMD_START_READ;
            2:       kind = CMD_READ_PTR1;
            default: kind = CMD_READ_PTR2;
        endcase
        r = $urandom_range(199);
        if (r < 20)
            len = 0;
        else if (r < 150)
            len = $urandom_range(1, 4);
        else if (r < 194)
            len = $urandom_range(5, 24);
        else if (r < 199)
            len = $urandom_range(25, 254);
        else
            len = 255;
        it                 = random_item(kind);
        it.transfer_length = len[7:0];
        // every payload byte that a write sends must be loaded first
        if (kind == CMD_START_WRITE) begin
            for (int i = 0; i < len; i++)
                if (!txn_sb.loaded[i])
                    load_payload(i[7:0]);
        end
        send_request(it);
    endtask

    // the event the bus would give next in the running transaction
    task automatic next_bus_event();
        if (txn_sb.phase == PH_R_DATA)
            send_request(random_item(CMD_RX_BYTE));
        else
            send_request(random_item(CMD_TX_READY));
    endtask

    task automatic send_noise();
        int c;
        c = $urandom_range(CMD_TX_READY, CMD_CODE_MAX);
        send_request(random_item(c[3:0]));
    endtask

    // one random step, mostly well-formed transactions
    task automatic random_step();
        int  r;
        logic [31:0] idx;
        r   = $urandom_range(99);
        idx = $urandom;
        if (txn_sb.phase == PH_IDLE) begin
            if (r < 12)
                load_payload(idx[7:0]);
            else if (r < 15)
                send_request(random_item(CMD_TICK));
            else if (r < 17)
                send_request(random_item(CMD_NACK));
            else if (r < 21) begin
                send_noise();
                return;
            end else
                begin_transaction();
        end else begin
            if (r < 6)
                send_request(random_item(CMD_TICK));
            else if (r < 9)
                send_request(random_item(CMD_NACK));
            else if (r < 12)
                load_payload(idx[7:0]);
            else if (r < 14)
                begin_transaction();
            else if (r < 19) begin
                send_noise();
                return;
            end else
                next_bus_event();
        end
        issued++;
    endtask

    task automatic random_phase();
        issued = 0;
        while (issued < PHASE_REQUESTS)
            random_step();
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (txn_sb.results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // finish the open transaction, drain, then write the timeout limit
    task automatic set_timeout(logic [16:0] limit_val);
        while (txn_sb.phase != PH_IDLE)
            next_bus_event();
        wait_for_results();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit_val;
        txn_sb.timeout_limit = limit_val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // directed cases
    task automatic run_directed();
        // idle: tick, nack, stray transmit ready and received byte
        send_cmd(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_NACK, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
        // payload loads at both ends of the store
        send_cmd(CMD_LOAD, 7'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_cmd(CMD_LOAD, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        send_cmd(CMD_LOAD, 7'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'hFF);
        // block write of two bytes
        send_cmd(CMD_START_WRITE, 7'h7F, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00);
        repeat (3) send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // zero-length write
        send_cmd(CMD_START_WRITE, 7'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
        repeat (2) send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // zero-length plain read
        send_cmd(CMD_START_READ, 7'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // one-byte read after a two-byte pointer
        send_cmd(CMD_READ_PTR2, 7'h2A, 8'h01, 8'h12, 8'h34, 8'h00, 8'h00);
        repeat (3) send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
        // address nack
        send_cmd(CMD_READ_PTR1, 7'h11, 8'h03, 8'h80, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_NACK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // read-address nack after the restart
        send_cmd(CMD_READ_PTR1, 7'h22, 8'h02, 8'h80, 8'h00, 8'h00, 8'h00);
        repeat (2) send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_NACK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // nack on the pointer byte, then a start while busy
        send_cmd(CMD_START_WRITE, 7'h33, 8'h01, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_NACK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_START_READ, 7'h44, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h3C, 8'h00);
        // unused command code
        send_cmd(CMD_CODE_MAX, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // main sequence
    initial begin
        int lim;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        random_phase();
        set_timeout(17'd1);
        random_phase();
        set_timeout(TICK_MAX);
        random_phase();
        lim = $urandom_range(2, 16);
        set_timeout(lim[16:0]);
        random_phase();
        lim = $urandom_range(17, 400);
        set_timeout(lim[16:0]);
        random_phase();
        set_timeout(TIMEOUT_RESET);
        random_phase();

        wait_for_results();
        repeat (6) @(posedge i_clk);
        if (txn_sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/i2cs_pkg.sv
hw/rtl/i2cs_if.sv
hw/rtl/i2cs_ram.sv
hw/rtl/i2c_master_transaction_sequencer.sv
hw/rtl/i2cs_checker.sv
tb/sv/i2c_master_transaction_sequencer_tb.sv
